>>> design/swgi_pkg.sv
// Shared types and constants for the stencil weighted gather interpolator.
`default_nettype none
package swgi_pkg;

  localparam int unsigned MAX_STENCILS = 256;
  localparam int unsigned MAX_DONORS   = 8;
  localparam int unsigned FIELD_DEPTH  = 4096;

  localparam int unsigned SIDX_W  = $clog2(MAX_STENCILS);
  localparam int unsigned SLOT_W  = $clog2(MAX_DONORS);
  localparam int unsigned LEN_W   = $clog2(MAX_DONORS + 1);
  localparam int unsigned CELL_W  = 12;
  localparam int unsigned FADDR_W = $clog2(FIELD_DEPTH);
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CC_W    = 13;
  localparam int unsigned STAB_DEPTH = MAX_STENCILS * MAX_DONORS;

  // weight * value product and an exact sum over all donors
  localparam int unsigned PROD_W = WGT_W + 1 + VAL_W;
  localparam int unsigned ACC_W  = PROD_W + SLOT_W;
  localparam int unsigned WSUM_W = WGT_W + SLOT_W;

  localparam logic [WGT_W-1:0]  ONE_Q15 = WGT_W'(32768);
  localparam logic [CC_W-1:0]   CELL_COUNT_RST = CC_W'(4096);
  localparam int unsigned       FRAC_SHIFT = 15;

  // APB: one 32-bit register at byte address 0
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_CELL_COUNT = '0;

  typedef enum logic [1:0] {
    CMD_SLOT  = 2'd0,
    CMD_FIELD = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2,
    ST_BADSUM = 2'd3
  } status_e;

  typedef struct packed {
    logic [CELL_W-1:0] donor;
    logic [WGT_W-1:0]  weight;
  } stab_ent_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctl_t;

endpackage : swgi_pkg
`default_nettype wire

>>> design/swgi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swgi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : swgi_ram
`default_nettype wire

>>> design/swgi_mac.sv
// Shared multiply-accumulate unit with weight sum and Q16.16 round/saturate.
`default_nettype none
module swgi_mac import swgi_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mac_ctl_t                 ctl_i,
  input  wire logic        [WGT_W-1:0]  weight_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  output logic                          busy_o,
  output logic             [WSUM_W-1:0] wsum_o,
  output logic signed      [VAL_W-1:0]  rounded_o
);

  logic                     pv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic        [WSUM_W-1:0] wsum_q;
  logic signed [ACC_W-1:0]  rnd;
  logic                     ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      prod_q <= $signed({1'b0, weight_i}) * value_i;
    end
    if (ctl_i.clr) begin
      acc_q  <= '0;
      wsum_q <= '0;
    end else begin
      if (pv_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
      if (ctl_i.vld) begin
        wsum_q <= wsum_q + WSUM_W'(weight_i);
      end
    end
  end

  // round half up, then floor by the arithmetic shift
  always_comb begin
    rnd = acc_q + ACC_W'(1 << (FRAC_SHIFT - 1));
    ovf = (rnd[ACC_W-1:FRAC_SHIFT+VAL_W-1] != '0) &&
          (rnd[ACC_W-1:FRAC_SHIFT+VAL_W-1] != '1);
    if (ovf) begin
      rounded_o = rnd[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      rounded_o = rnd[FRAC_SHIFT+VAL_W-1:FRAC_SHIFT];
    end
  end

  assign busy_o = pv_q;
  assign wsum_o = wsum_q;

endmodule : swgi_mac
`default_nettype wire

>>> design/stencil_weighted_gather_interpolator.sv
// Top level: stencil/field stores, query sequencer and APB register.
// Flow: a write goes to S_RESP once accepted, an empty stencil via S_LEN, and
//   a query via S_LEN, S_RUN and S_FIN (len = stencil length, 1..8): one slot per
//   cycle through the stencil memory, the field memory and the shared multiplier.
// Throughput: one item at a time; the next is taken the cycle after the result
//   is registered at the output.
// Reset (async, active low): all stencils empty, cell_count 4096.
`default_nettype none
module stencil_weighted_gather_interpolator import swgi_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // item input
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               command_i,
  input  wire logic [SIDX_W-1:0]        stencil_index_i,
  input  wire logic [SLOT_W-1:0]        slot_i,
  input  wire logic                     last_slot_i,
  input  wire logic [CELL_W-1:0]        donor_cell_i,
  input  wire logic [WGT_W-1:0]         weight_i,
  input  wire logic signed [VAL_W-1:0]  value_i,
  // result output
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [VAL_W-1:0]       result_o,
  output logic [1:0]                    status_o,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_AW-1:0]        paddr,
  input  wire logic [APB_DW-1:0]        pwdata,
  output logic      [APB_DW-1:0]        prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item
    S_LEN,    // stencil length read in flight
    S_RUN,    // walking donor slots through the MAC
    S_FIN,    // weight sum check, round and saturate
    S_RESP    // result waits for the output register
  } state_e;

  state_e state_q;

  logic [CC_W-1:0]         cell_count_q;
  logic [SIDX_W-1:0]       sidx_q;
  logic [LEN_W-1:0]        len_q;
  logic [LEN_W-1:0]        k_q;
  logic                    p1_q;      // stencil read data valid
  logic                    p2_q;      // field read data valid
  logic [WGT_W-1:0]        w2_q;      // weight aligned with field data
  logic signed [VAL_W-1:0] res_q;
  status_e                 res_st_q;
  logic                    out_vld_q;
  logic signed [VAL_W-1:0] out_res_q;
  status_e                 out_st_q;
  logic [MAX_STENCILS-1:0] len_vld_q;

  // item accept and write checks
  logic    accept;
  cmd_e    cmd;
  logic    cell_ok;
  logic    slot_ok;
  logic    stab_we;
  logic    fld_we;
  logic    len_we;
  logic    out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(command_i);
  assign cell_ok    = ({1'b0, donor_cell_i} < cell_count_q);
  assign slot_ok    = cell_ok && (weight_i <= ONE_Q15);
  assign stab_we    = accept && (cmd == CMD_SLOT) && slot_ok;
  assign len_we     = stab_we && last_slot_i;
  assign fld_we     = accept && (cmd == CMD_FIELD) && cell_ok;
  assign out_free   = !out_vld_q || !out_stall_i;

  // stencil length store; an entry never written reads as empty
  logic [LEN_W-1:0] len_rdata;
  logic [LEN_W-1:0] len_eff;

  swgi_ram #(.WIDTH(LEN_W), .DEPTH(MAX_STENCILS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (stencil_index_i),
    .wdata_i (LEN_W'(slot_i) + LEN_W'(1)),
    .re_i    (accept),
    .raddr_i (stencil_index_i),
    .rdata_o (len_rdata)
  );

  assign len_eff = len_vld_q[sidx_q] ? len_rdata : '0;

  // stencil slot store
  logic      issue;
  stab_ent_t stab_wdata;
  stab_ent_t stab_rdata;
  logic [$bits(stab_ent_t)-1:0] stab_rraw;

  assign issue      = (state_q == S_RUN) && (k_q < len_q);
  assign stab_wdata = '{donor: donor_cell_i, weight: weight_i};
  assign stab_rdata = stab_ent_t'(stab_rraw);

  swgi_ram #(.WIDTH($bits(stab_ent_t)), .DEPTH(STAB_DEPTH)) u_stab_ram (
    .clk_i   (clk_i),
    .we_i    (stab_we),
    .waddr_i ({stencil_index_i, slot_i}),
    .wdata_i (stab_wdata),
    .re_i    (issue),
    .raddr_i ({sidx_q, k_q[SLOT_W-1:0]}),
    .rdata_o (stab_rraw)
  );

  // field value store, read with the donor cell just fetched
  logic [VAL_W-1:0] fld_rdata;

  swgi_ram #(.WIDTH(VAL_W), .DEPTH(FIELD_DEPTH)) u_fld_ram (
    .clk_i   (clk_i),
    .we_i    (fld_we),
    .waddr_i (FADDR_W'(donor_cell_i)),
    .wdata_i (value_i),
    .re_i    (p1_q),
    .raddr_i (FADDR_W'(stab_rdata.donor)),
    .rdata_o (fld_rdata)
  );

  // shared multiply-accumulate
  mac_ctl_t                mac_ctl;
  logic                    mac_busy;
  logic [WSUM_W-1:0]       mac_wsum;
  logic signed [VAL_W-1:0] mac_rounded;

  assign mac_ctl.clr = (state_q == S_LEN);
  assign mac_ctl.vld = p2_q;

  swgi_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .weight_i  (w2_q),
    .value_i   (fld_rdata),
    .busy_o    (mac_busy),
    .wsum_o    (mac_wsum),
    .rounded_o (mac_rounded)
  );

  // all slots issued and the pipe is empty
  logic run_done;
  assign run_done = (k_q == len_q) && !p1_q && !p2_q && !mac_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sidx_q    <= '0;
      len_q     <= '0;
      k_q       <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      w2_q      <= '0;
      res_q     <= '0;
      res_st_q  <= ST_OK;
      out_vld_q <= 1'b0;
      out_res_q <= '0;
      out_st_q  <= ST_OK;
      len_vld_q <= '0;
    end else begin
      p1_q <= issue;
      p2_q <= p1_q;
      if (p1_q) begin
        w2_q <= stab_rdata.weight;
      end
      if (len_we) begin
        len_vld_q[stencil_index_i] <= 1'b1;
      end
      // result taken with no new one behind it
      if (out_vld_q && !out_stall_i && (state_q != S_RESP)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            sidx_q <= stencil_index_i;
            res_q  <= '0;
            unique case (cmd)
              CMD_SLOT: begin
                res_st_q <= slot_ok ? ST_OK : ST_REJECT;
                state_q  <= S_RESP;
              end
              CMD_FIELD: begin
                res_st_q <= cell_ok ? ST_OK : ST_REJECT;
                state_q  <= S_RESP;
              end
              CMD_QUERY: begin
                state_q <= S_LEN;
              end
              default: begin
                res_st_q <= ST_REJECT;
                state_q  <= S_RESP;
              end
            endcase
          end
        end
        S_LEN: begin
          if ((len_eff == '0) || (len_eff > LEN_W'(MAX_DONORS))) begin
            res_q    <= '0;
            res_st_q <= ST_EMPTY;
            state_q  <= S_RESP;
          end else begin
            len_q   <= len_eff;
            k_q     <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            k_q <= k_q + LEN_W'(1);
          end
          if (run_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (mac_wsum != WSUM_W'(ONE_Q15)) begin
            res_q    <= '0;
            res_st_q <= ST_BADSUM;
          end else begin
            res_q    <= mac_rounded;
            res_st_q <= ST_OK;
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_res_q <= res_q;
            out_st_q  <= res_st_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = out_res_q;
  assign status_o    = out_st_q;

  // configuration register
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_AW-1:2] == REG_CELL_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? APB_DW'(cell_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CELL_COUNT_RST;
    end else if (cfg_wr) begin
      cell_count_q <= pwdata[CC_W-1:0];
    end
  end

  // slot counter never runs past the stencil length
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (k_q <= len_q))
    else $error("slot counter beyond stencil length");

  // the MAC is only fed while a query walks its slots
  a_mac_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.vld |-> (state_q == S_RUN))
    else $error("MAC fed outside a query");

  // once an item is taken the block holds off the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("second item taken while busy");

  // a result appears only when a pending result is handed over
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_RESP))
    else $error("result without a pending item");

  // a finished query leaves the pipe empty
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (!p1_q && !p2_q && !mac_busy))
    else $error("query finished with slots in flight");

endmodule : stencil_weighted_gather_interpolator
`default_nettype wire

>>> tb/swgi_scoreboard_pkg.sv
// Item and result types plus the scoreboard that predicts and checks results.
`default_nettype none
package swgi_scoreboard_pkg;
  import swgi_pkg::*;

  // command code that the block treats as a rejected no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [SIDX_W-1:0] stencil_index;
    logic [SLOT_W-1:0] slot;
    logic              last_slot;
    logic [CELL_W-1:0] donor_cell;
    logic [WGT_W-1:0]  weight;
    logic [VAL_W-1:0]  value;
  } gather_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result;
    status_e          status;
  } gather_result_t;

  class gather_scoreboard;
    logic [CELL_W-1:0] donor_tab [STAB_DEPTH];
    logic [WGT_W-1:0]  weight_tab [STAB_DEPTH];
    bit                slot_set [STAB_DEPTH];
    logic [LEN_W-1:0]  len_tab [MAX_STENCILS];
    logic [VAL_W-1:0]  field_tab [FIELD_DEPTH];
    bit                field_set [FIELD_DEPTH];
    logic [CC_W-1:0]   cell_count;
    gather_result_t    due_results [$];
    int                errors;

    function new();
      foreach (len_tab[i]) len_tab[i] = '0;
      cell_count = CELL_COUNT_RST;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function bit cell_fits(logic [CELL_W-1:0] cell_idx);
      return {1'b0, cell_idx} < cell_count;
    endfunction

    // true when a query of this stencil reads only slots and values written
    function bit gather_safe(logic [SIDX_W-1:0] sidx);
      int base;
      base = int'(sidx) * MAX_DONORS;
      for (int k = 0; k < int'(len_tab[sidx]); k++) begin
        if (!slot_set[base + k] || !field_set[donor_tab[base + k]]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // exact Q17.31 sum, rounded to nearest (ties up) in Q16.16, saturated
    function gather_result_t weighted_gather(logic [SIDX_W-1:0] sidx);
      gather_result_t r;
      longint acc;
      longint w;
      longint v;
      int unsigned wsum;
      int base;
      r.result = '0;
      r.status = ST_OK;
      if (len_tab[sidx] == '0) begin
        r.status = ST_EMPTY;
        return r;
      end
      base = int'(sidx) * MAX_DONORS;
      acc = 0;
      wsum = 0;
      for (int k = 0; k < int'(len_tab[sidx]); k++) begin
        w = weight_tab[base + k];
        v = $signed(field_tab[donor_tab[base + k]]);
        wsum += weight_tab[base + k];
        acc += w * v;
      end
      if (wsum != ONE_Q15) begin
        r.status = ST_BADSUM;
        return r;
      end
      acc = (acc + 16384) >>> FRAC_SHIFT;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      r.result = acc[31:0];
      return r;
    endfunction

    function void note_item(gather_item_t it);
      gather_result_t r;
      int pos;
      r.result = '0;
      r.status = ST_OK;
      pos = int'(it.stencil_index) * MAX_DONORS + int'(it.slot);
      case (it.command)
        CMD_SLOT: begin
          if (!cell_fits(it.donor_cell) || it.weight > ONE_Q15) begin
            r.status = ST_REJECT;
          end else begin
            donor_tab[pos] = it.donor_cell;
            weight_tab[pos] = it.weight;
            slot_set[pos] = 1'b1;
            if (it.last_slot) len_tab[it.stencil_index] = LEN_W'(it.slot) + LEN_W'(1);
          end
        end
        CMD_FIELD: begin
          if (!cell_fits(it.donor_cell)) begin
            r.status = ST_REJECT;
          end else begin
            field_tab[it.donor_cell] = it.value;
            field_set[it.donor_cell] = 1'b1;
          end
        end
        CMD_QUERY: r = weighted_gather(it.stencil_index);
        default: r.status = ST_REJECT;
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(logic [VAL_W-1:0] result, logic [1:0] status);
      gather_result_t e;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d status %0d with nothing outstanding",
                         $signed(result), status));
        return;
      end
      e = due_results.pop_front();
      if (result !== e.result)
        report($sformatf("result %0d, expected %0d", $signed(result), $signed(e.result)));
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
    endfunction
  endclass

endpackage : swgi_scoreboard_pkg
`default_nettype wire

>>> tb/tb_stencil_weighted_gather_interpolator.sv
// Testbench top: drives random and directed items, APB config and checks results.
`default_nettype none
module tb_stencil_weighted_gather_interpolator;
  import swgi_pkg::*;
  import swgi_scoreboard_pkg::*;

  // receiver holds off this long once, so the block fills and stalls its input
  localparam int HOLD_CYCLES = 250;
  localparam int HOLD_AT     = 300;
  // a query takes longest with a full stencil of MAX_DONORS slots
  localparam int DRAIN_CYCLES = 20;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               command = '0;
  logic [SIDX_W-1:0]        stencil_index = '0;
  logic [SLOT_W-1:0]        slot = '0;
  logic                     last_slot = 1'b0;
  logic [CELL_W-1:0]        donor_cell = '0;
  logic [WGT_W-1:0]         weight = '0;
  logic signed [VAL_W-1:0]  value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [VAL_W-1:0]  result;
  logic [1:0]               status;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  gather_scoreboard sb;
  // when set, neither side inserts idle cycles
  bit idle_free = 1'b0;
  int sent = 0;
  int results_seen = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stencil_weighted_gather_interpolator uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .stencil_index_i (stencil_index),
    .slot_i          (slot),
    .last_slot_i     (last_slot),
    .donor_cell_i    (donor_cell),
    .weight_i        (weight),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_o        (result),
    .status_o        (status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  function automatic int draw_gap();
    return idle_free ? 0 : $urandom_range(0, 11);
  endfunction

  // field values lean on the extremes now and then
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // every field random; the builders below override what matters
  function automatic gather_item_t rand_item();
    gather_item_t it;
    it.command = 2'($urandom_range(0, 3));
    it.stencil_index = SIDX_W'($urandom_range(0, MAX_STENCILS - 1));
    it.slot = SLOT_W'($urandom_range(0, MAX_DONORS - 1));
    it.last_slot = 1'($urandom_range(0, 1));
    it.donor_cell = CELL_W'($urandom_range(0, FIELD_DEPTH - 1));
    it.weight = WGT_W'($urandom_range(0, 65535));
    it.value = rand_value();
    return it;
  endfunction

  function automatic gather_item_t mk_slot(int sidx, int sl, bit last, int cell_idx, int w);
    gather_item_t it;
    it = rand_item();
    it.command = CMD_SLOT;
    it.stencil_index = SIDX_W'(sidx);
    it.slot = SLOT_W'(sl);
    it.last_slot = last;
    it.donor_cell = CELL_W'(cell_idx);
    it.weight = WGT_W'(w);
    return it;
  endfunction

  function automatic gather_item_t mk_field(int cell_idx, logic [VAL_W-1:0] v);
    gather_item_t it;
    it = rand_item();
    it.command = CMD_FIELD;
    it.donor_cell = CELL_W'(cell_idx);
    it.value = v;
    return it;
  endfunction

  function automatic gather_item_t mk_query(int sidx);
    gather_item_t it;
    it = rand_item();
    it.command = CMD_QUERY;
    it.stencil_index = SIDX_W'(sidx);
    return it;
  endfunction

  // donor cells below cell_count, often from a small pool so values get reused
  function automatic int pick_cell(int cc);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, (cc > 16) ? 15 : cc - 1);
    return $urandom_range(0, cc - 1);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the caller either offers the next item or drops valid.
  task automatic send_item(gather_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command       <= it.command;
    stencil_index <= it.stencil_index;
    slot          <= it.slot;
    last_slot     <= it.last_slot;
    donor_cell    <= it.donor_cell;
    weight        <= it.weight;
    value         <= it.value;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(it);
    sent++;
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // one APB transfer: setup then access; starts and ends at a falling edge
  task automatic apb_xfer(bit wr, logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_CELL_COUNT, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
  endtask

  // only with the block idle; the register is read back after the write
  task automatic set_cell_count(int cc);
    logic [APB_DW-1:0] rd;
    wait_idle();
    apb_xfer(1'b1, APB_DW'(cc), rd);
    sb.cell_count = CC_W'(cc);
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DW'(cc))
      sb.report($sformatf("cell_count reads %0d, written %0d", rd, cc));
  endtask

  // queries that would touch unwritten slots or values are turned into no-ops
  task automatic query_if_safe(int sidx);
    gather_item_t it;
    it = mk_query(sidx);
    if (!sb.gather_safe(it.stencil_index)) it.command = CMD_UNUSED;
    send_item(it);
  endtask

  task automatic noise_item(int cc);
    gather_item_t it;
    it = rand_item();
    if ($urandom_range(0, 1) == 0) it.weight = WGT_W'($urandom_range(0, ONE_Q15));
    if (cc > 0 && $urandom_range(0, 2) != 0) it.donor_cell = CELL_W'(pick_cell(cc));
    if (it.command == CMD_QUERY && !sb.gather_safe(it.stencil_index))
      it.command = CMD_UNUSED;
    send_item(it);
  endtask

  // Well-formed stencil: load donor values, write every slot up to the length
  // (sometimes last slot first), then query. Some sets miss unity weight sum,
  // some carry a rejected write in the middle.
  task automatic build_stencil(int cc);
    int sidx;
    int len;
    int rem;
    int k;
    bit bad_sum;
    bit rev;
    int cells [MAX_DONORS];
    int wts [MAX_DONORS];
    sidx = $urandom_range(0, MAX_STENCILS - 1);
    len = $urandom_range(1, MAX_DONORS);
    bad_sum = ($urandom_range(0, 5) == 0);
    rev = 1'($urandom_range(0, 1));
    rem = ONE_Q15;
    for (int i = 0; i < len; i++) begin
      cells[i] = pick_cell(cc);
      if (!sb.field_set[cells[i]] || $urandom_range(0, 2) == 0)
        send_item(mk_field(cells[i], rand_value()));
      if (i == len - 1) begin
        wts[i] = rem;
      end else begin
        wts[i] = $urandom_range(0, rem);
        rem -= wts[i];
      end
    end
    if (bad_sum) begin
      if (wts[len-1] > 0) wts[len-1] -= $urandom_range(1, wts[len-1]);
      else wts[len-1] += $urandom_range(1, 100);
    end
    for (int j = 0; j < len; j++) begin
      k = rev ? len - 1 - j : j;
      if (j == 1 && $urandom_range(0, 5) == 0)
        send_item(mk_slot(sidx, $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                          pick_cell(cc), $urandom_range(ONE_Q15 + 1, 65535)));
      send_item(mk_slot(sidx, k, k == len - 1, cells[k], wts[k]));
    end
    query_if_safe(sidx);
    if ($urandom_range(0, 3) == 0) query_if_safe($urandom_range(0, MAX_STENCILS - 1));
  endtask

  // Stimulus: reset, directed extremes at the reset cell_count, then random
  // phases across cell_count settings, including zero and both extremes.
  initial begin
    gather_item_t it;
    int cc_plan [6];
    int budget [6];
    int target;
    sb = new();
    cc_plan = '{4096, 1, 4095, 0, 0, 4096};
    budget  = '{330, 160, 330, 25, 250, 230};
    cc_plan[4] = $urandom_range(2, 4094);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty stencils at both ends of the index range
    send_item(mk_query(0));
    send_item(mk_query(MAX_STENCILS - 1));
    // value extremes at the lowest and highest cells
    send_item(mk_field(FIELD_DEPTH - 1, 32'h7FFF_FFFF));
    send_item(mk_field(0, 32'h8000_0000));
    send_item(mk_field(1, 32'hFFFF_FFFF));
    // single donor of full weight: largest positive result
    send_item(mk_slot(MAX_STENCILS - 1, 0, 1'b1, FIELD_DEPTH - 1, ONE_Q15));
    send_item(mk_query(MAX_STENCILS - 1));
    // full eight-donor stencil, equal weights, mixing the extremes
    for (int i = 0; i < MAX_DONORS; i++)
      send_item(mk_slot(1, i, i == MAX_DONORS - 1,
                        (i % 3 == 0) ? 0 : (i % 3 == 1) ? FIELD_DEPTH - 1 : 1, 4096));
    send_item(mk_query(1));
    // weights above 1.0 are rejected
    send_item(mk_slot(3, 2, 1'b1, 5, ONE_Q15 + 1));
    send_item(mk_slot(3, MAX_DONORS - 1, 1'b1, FIELD_DEPTH - 1, 16'hFFFF));
    // undefined command with every bit set
    it = '1;
    it.command = CMD_UNUSED;
    send_item(it);
    // zero weight: sum is not one
    send_item(mk_slot(2, 0, 1'b1, 0, 0));
    send_item(mk_query(2));
    // slot rewrite without last slot keeps the length, sum now short
    send_item(mk_slot(MAX_STENCILS - 1, 0, 1'b0, 0, 16384));
    send_item(mk_query(MAX_STENCILS - 1));

    for (int p = 0; p < 6; p++) begin
      if (p > 0) set_cell_count(cc_plan[p]);
      // stencils built earlier, now maybe with donors above cell_count
      query_if_safe(1);
      query_if_safe(MAX_STENCILS - 1);
      target = sent + budget[p];
      while (sent < target) begin
        if (cc_plan[p] == 0 || $urandom_range(0, 4) == 0) noise_item(cc_plan[p]);
        else build_stencil(cc_plan[p]);
        if ($urandom_range(0, 7) == 0) idle_free = !idle_free;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("[stencil_weighted_gather_interpolator] OK");
    end else begin
      $display("[stencil_weighted_gather_interpolator] ERROR");
    end
    $finish;
  end

  // Result side: random stall per item, one long hold-off, checks at the
  // rising edge on which a result is taken.
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_result(result, status);
      results_seen++;
      @(negedge clk);
    end
  end

  // run limit, several times the slowest legal run
  initial begin
    #6000000;
    $display("[stencil_weighted_gather_interpolator] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
